>>> rtl/core/ksm_pkg.sv
// Shared types and constants of the keypoint SAD stereo matcher.
package ksm_pkg;

  localparam int MAX_CANDIDATES_DEF = 512;
  localparam int COORD_BITS_DEF     = 12;
  localparam int PATCH_ROWS         = 7;
  localparam int PATCH_COLS         = 7;
  localparam int ROW_BITS           = 56;
  localparam int PATCH_BITS         = PATCH_ROWS * ROW_BITS;
  localparam int REG_BITS           = 12;
  localparam int SAD_BITS           = 14;
  localparam int ROW_SAD_BITS       = 11;
  localparam int IDX_OUT_BITS       = 9;
  localparam int CFG_IDX_BITS       = 1;

  localparam logic [1:0] MODE_STORE = 2'd0;
  localparam logic [1:0] MODE_QUERY = 2'd1;
  localparam logic [1:0] MODE_CLEAR = 2'd2;

  localparam logic [CFG_IDX_BITS-1:0] CFG_MAX_DISP = 1'b0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_MAX_ROW  = 1'b1;

  localparam logic [REG_BITS-1:0] MAX_DISP_RST = 12'd120;
  localparam logic [REG_BITS-1:0] MAX_ROW_RST  = 12'd2;

  // Sum of absolute differences over one patch row of seven pixels.
  function automatic logic [ROW_SAD_BITS-1:0] row_sad(input logic [ROW_BITS-1:0] a,
                                                      input logic [ROW_BITS-1:0] b);
    logic [ROW_SAD_BITS-1:0] s;
    logic [7:0] pa;
    logic [7:0] pb;
    s = '0;
    for (int c = 0; c < PATCH_COLS; c++) begin
      pa = a[8*c +: 8];
      pb = b[8*c +: 8];
      s  = s + ROW_SAD_BITS'((pa > pb) ? (pa - pb) : (pb - pa));
    end
    return s;
  endfunction

endpackage

>>> rtl/core/ksm_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module ksm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

>>> rtl/core/ksm_front.sv
// Input stage: accepts requests and queues them in a short FIFO for the back end.
module ksm_front import ksm_pkg::*; #(
  parameter int REQ_BITS = 8
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [REQ_BITS-1:0] in_req,
  output logic                q_valid,
  input  logic                q_ready,
  output logic [REQ_BITS-1:0] q_req
);

  // Two-entry queue.
  logic [REQ_BITS-1:0] slot_r [2];
  logic [1:0]          cnt_r, cnt_nxt;
  logic                rd_r, rd_nxt;
  logic                wr_r, wr_nxt;
  logic                push, pop;

  assign in_ready = (cnt_r != 2'd2);
  assign q_valid  = (cnt_r != 2'd0);
  assign q_req    = slot_r[rd_r];
  assign push     = in_valid && in_ready;
  assign pop      = q_valid && q_ready;

  always_comb begin
    cnt_nxt = cnt_r + 2'(push) - 2'(pop);
    rd_nxt  = rd_r ^ pop;
    wr_nxt  = wr_r ^ push;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
      rd_r  <= 1'b0;
      wr_r  <= 1'b0;
    end else begin
      cnt_r <= cnt_nxt;
      rd_r  <= rd_nxt;
      wr_r  <= wr_nxt;
    end
    if (push) begin
      slot_r[wr_r] <= in_req;
    end
  end

`ifndef SYNTHESIS
  a_no_overfill: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r == 2'd2 |-> !in_ready) else $error("queue accepts while full");
  a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
    (push && !pop) |=> cnt_r == $past(cnt_r) + 2'd1) else $error("queue count slip");
  a_hold_empty: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r == 2'd0 |-> !q_valid) else $error("queue presents data while empty");
`endif

endmodule

>>> rtl/core/ksm_back.sv
// Execution engine: stores and clears candidates, scans the table on queries, builds results.
module ksm_back import ksm_pkg::*; #(
  parameter int MAX_CANDIDATES = MAX_CANDIDATES_DEF,
  parameter int COORD_BITS     = COORD_BITS_DEF,
  parameter int REQ_BITS       = 8
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                q_valid,
  output logic                q_ready,
  input  logic [REQ_BITS-1:0] q_req,
  input  logic [REG_BITS-1:0] max_disp,
  input  logic [REG_BITS-1:0] max_row,
  output logic                out_tvalid,
  input  logic                out_tready,
  output logic                res_found,
  output logic [IDX_OUT_BITS-1:0] res_index,
  output logic [SAD_BITS-1:0] res_sad,
  output logic [COORD_BITS-1:0]   res_x,
  output logic [COORD_BITS-1:0]   res_y,
  output logic                res_ovf
);

  localparam int AW = $clog2(MAX_CANDIDATES);
  localparam int CW = AW + 1;
  localparam int EW = 2 * COORD_BITS + PATCH_BITS;

  typedef enum logic [2:0] {S_IDLE, S_SCAN, S_LAST1, S_LAST2, S_OUT} state_t;

  state_t state_r;
  logic [CW-1:0] count_r;
  logic [AW-1:0] addr_r;
  logic [CW-1:0] issued_r;
  logic [1:0]    mode;
  logic [COORD_BITS-1:0] qx_r, qy_r;
  logic [PATCH_BITS-1:0] qp_r;
  logic [COORD_BITS-1:0] px, py;
  logic [PATCH_BITS-1:0] pp;

  assign mode = q_req[1:0];
  assign px   = q_req[2 +: COORD_BITS];
  assign py   = q_req[2+COORD_BITS +: COORD_BITS];
  assign pp   = q_req[2+2*COORD_BITS +: PATCH_BITS];

  // Table memory, one entry per candidate.
  logic          wr_en;
  logic [EW-1:0] rd_data;
  assign wr_en = (state_r == S_IDLE) && q_valid && mode == MODE_STORE &&
                 (count_r < CW'(MAX_CANDIDATES));

  ksm_ram #(.WIDTH(EW), .DEPTH(MAX_CANDIDATES)) u_table (
    .clk    (clk),
    .wr_en  (wr_en),
    .wr_addr(count_r[AW-1:0]),
    .wr_data({pp, py, px}),
    .rd_addr(addr_r),
    .rd_data(rd_data)
  );

  // Stage 1: read data valid flag and index; stage 2: row sums and eligibility.
  logic          v1_r, v2_r;
  logic [AW-1:0] i1_r, i2_r;
  logic [COORD_BITS-1:0] x2_r, y2_r;
  logic [ROW_SAD_BITS-1:0] rs_r [PATCH_ROWS];
  logic          el2_r;

  logic [COORD_BITS-1:0] cx, cy;
  logic [PATCH_BITS-1:0] cp;
  logic [COORD_BITS:0]   dx, dy_raw;
  logic [COORD_BITS-1:0] dy;
  logic                  elig;
  assign cx     = rd_data[0 +: COORD_BITS];
  assign cy     = rd_data[COORD_BITS +: COORD_BITS];
  assign cp     = rd_data[2*COORD_BITS +: PATCH_BITS];
  assign dx     = {1'b0, qx_r} - {1'b0, cx};
  assign dy_raw = {1'b0, qy_r} - {1'b0, cy};
  assign dy     = dy_raw[COORD_BITS] ? COORD_BITS'(-dy_raw) : dy_raw[COORD_BITS-1:0];
  assign elig   = !dx[COORD_BITS] && (dx != '0) &&
                  ({{(32-COORD_BITS-1){1'b0}}, dx} <= {20'd0, max_disp}) &&
                  ({{(32-COORD_BITS){1'b0}}, dy} <= {20'd0, max_row});

  logic [SAD_BITS-1:0] sad2;
  always_comb begin
    sad2 = '0;
    for (int r = 0; r < PATCH_ROWS; r++) begin
      sad2 = sad2 + SAD_BITS'(rs_r[r]);
    end
  end

  logic                found_r;
  logic [AW-1:0]       best_r;
  logic [SAD_BITS-1:0] bsad_r;
  logic [COORD_BITS-1:0] bx_r, by_r;
  logic                ovf_r;

  assign q_ready    = (state_r == S_IDLE);
  assign out_tvalid = (state_r == S_OUT);
  assign res_found  = found_r;
  assign res_index  = found_r ? IDX_OUT_BITS'(best_r) : '0;
  assign res_sad    = found_r ? bsad_r : '0;
  assign res_x      = found_r ? bx_r : '0;
  assign res_y      = found_r ? by_r : '0;
  assign res_ovf    = ovf_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      count_r <= '0;
      v1_r    <= 1'b0;
      v2_r    <= 1'b0;
      found_r <= 1'b0;
      ovf_r   <= 1'b0;
    end else begin
      v1_r <= (state_r == S_SCAN);
      v2_r <= v1_r;
      unique case (state_r)
        S_IDLE: begin
          if (q_valid) begin
            qx_r <= px;
            qy_r <= py;
            qp_r <= pp;
            found_r <= 1'b0;
            ovf_r   <= 1'b0;
            addr_r   <= '0;
            issued_r <= '0;
            if (mode == MODE_STORE) begin
              if (count_r < CW'(MAX_CANDIDATES)) begin
                count_r <= count_r + 1'b1;
              end else begin
                ovf_r   <= 1'b1;
                state_r <= S_OUT;
              end
            end else if (mode == MODE_CLEAR) begin
              count_r <= '0;
            end else if (mode == MODE_QUERY) begin
              state_r <= (count_r == '0) ? S_OUT : S_SCAN;
            end
          end
        end
        S_SCAN: begin
          i1_r     <= addr_r;
          addr_r   <= addr_r + 1'b1;
          issued_r <= issued_r + 1'b1;
          if (issued_r + 1'b1 == count_r) begin
            state_r <= S_LAST1;
          end
        end
        S_LAST1: state_r <= S_LAST2;
        S_LAST2: state_r <= S_OUT;
        S_OUT: begin
          if (out_tready) begin
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
      if (v2_r && el2_r && (!found_r || sad2 < bsad_r)) begin
        found_r <= 1'b1;
        bsad_r  <= sad2;
        best_r  <= i2_r;
        bx_r    <= x2_r;
        by_r    <= y2_r;
      end
    end
    i2_r  <= i1_r;
    x2_r  <= cx;
    y2_r  <= cy;
    el2_r <= elig;
    for (int r = 0; r < PATCH_ROWS; r++) begin
      rs_r[r] <= row_sad(qp_r[r*ROW_BITS +: ROW_BITS], cp[r*ROW_BITS +: ROW_BITS]);
    end
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(MAX_CANDIDATES)) else $error("candidate count beyond capacity");
  a_ovf_only_out: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && res_ovf) |-> !res_found) else $error("overflow result with match");
  a_out_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |=> out_tvalid && $stable(res_sad))
    else $error("result dropped while stalled");
`endif

endmodule

>>> rtl/core/keypoint_sad_stereo_matcher_top.sv
// Top level of the keypoint SAD stereo matcher.
// Right keypoints (mode store) are written to a candidate table of MAX_CANDIDATES entries;
// each left keypoint (mode query) scans every stored candidate, one table entry per cycle
// from a single memory read port, and returns the eligible candidate with the smallest SAD,
// the first one winning a tie. A request is registered in the queue before the engine
// takes it. A query then passes the engine through a scan state for each stored candidate,
// two drain states and an output state that holds until its result is taken; with an empty
// table it goes straight to the output state. A store or a clear leaves the engine idle, and
// a store into a full table gives one result with table_overflow set. Requests are queued
// in a two-entry FIFO ahead of the engine, and the result stays registered until taken. The
// user must write configuration only while the block is idle; the block does not enforce it.
module keypoint_sad_stereo_matcher_top import ksm_pkg::*; #(
  parameter int MAX_CANDIDATES = MAX_CANDIDATES_DEF,
  parameter int COORD_BITS     = COORD_BITS_DEF
) (
  input  logic clk,
  input  logic rst_n,
  input  logic in_tvalid,
  output logic in_tready,
  // mode, point_x, point_y, patch_row0 .. patch_row6 from the lowest bit up
  input  logic [((2+2*COORD_BITS+PATCH_BITS+7)/8)*8-1:0] in_tdata,
  output logic out_tvalid,
  input  logic out_tready,
  // match_found, best_index, min_sad, best_x, best_y, table_overflow from the lowest bit up
  output logic [((1+IDX_OUT_BITS+SAD_BITS+2*COORD_BITS+1+7)/8)*8-1:0] out_tdata,
  input  logic                    cfg_we,
  input  logic [CFG_IDX_BITS-1:0] cfg_index,
  input  logic [REG_BITS-1:0]     cfg_data
);

  localparam int REQ_BITS = 2 + 2 * COORD_BITS + PATCH_BITS;
  localparam int OUT_BITS = 1 + IDX_OUT_BITS + SAD_BITS + 2 * COORD_BITS + 1;
  localparam int OUT_W    = ((OUT_BITS + 7) / 8) * 8;

  // Configuration registers.
  logic [REG_BITS-1:0] max_disp_r, max_row_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_disp_r <= MAX_DISP_RST;
      max_row_r  <= MAX_ROW_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_MAX_DISP: max_disp_r <= cfg_data;
        CFG_MAX_ROW:  max_row_r  <= cfg_data;
        default: ;
      endcase
    end
  end

  logic                q_valid, q_ready;
  logic [REQ_BITS-1:0] q_req;

  ksm_front #(.REQ_BITS(REQ_BITS)) u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_valid(in_tvalid),
    .in_ready(in_tready),
    .in_req  (in_tdata[REQ_BITS-1:0]),
    .q_valid (q_valid),
    .q_ready (q_ready),
    .q_req   (q_req)
  );

  logic                    found, ovf;
  logic [IDX_OUT_BITS-1:0] idx;
  logic [SAD_BITS-1:0]     sad;
  logic [COORD_BITS-1:0]   bx, by;

  ksm_back #(
    .MAX_CANDIDATES(MAX_CANDIDATES),
    .COORD_BITS    (COORD_BITS),
    .REQ_BITS      (REQ_BITS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_ready   (q_ready),
    .q_req     (q_req),
    .max_disp  (max_disp_r),
    .max_row   (max_row_r),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .res_found (found),
    .res_index (idx),
    .res_sad   (sad),
    .res_x     (bx),
    .res_y     (by),
    .res_ovf   (ovf)
  );

  assign out_tdata = OUT_W'({ovf, by, bx, sad, idx, found});

endmodule

>>> tb/sv/keypoint_sad_stereo_matcher_top_test.sv
// Self-checking testbench for the keypoint SAD stereo matcher top level.
`timescale 1ns / 100ps

module keypoint_sad_stereo_matcher_top_test;
  import ksm_pkg::*;

  localparam int NCAND    = 512;
  localparam int IN_BITS  = ((2 + 24 + PATCH_BITS + 7) / 8) * 8;
  localparam int OUT_BITS = ((1 + IDX_OUT_BITS + SAD_BITS + 24 + 1 + 7) / 8) * 8;
  localparam int WATCHDOG = 20000;
  localparam logic [1:0] MODE_UNUSED = 2'd3;

  // One match result, in the order of the result channel.
  typedef struct packed {
    logic        overflow;
    logic [11:0] y;
    logic [11:0] x;
    logic [13:0] sad;
    logic [8:0]  idx;
    logic        found;
  } match_t;

  // Mirror of the candidate table and the two limit registers, plus the queue of
  // results the block owes us.
  class match_scoreboard;
    logic [11:0] disp_limit;
    logic [11:0] row_limit;
    logic [11:0] tab_x[NCAND];
    logic [11:0] tab_y[NCAND];
    logic [ROW_BITS-1:0] tab_patch[NCAND][PATCH_ROWS];
    int count;
    match_t owed[$];
    int errors;
    int checked;

    function new();
      disp_limit = MAX_DISP_RST;
      row_limit  = MAX_ROW_RST;
      count = 0;
      errors = 0;
      checked = 0;
    endfunction

    function void set_reg(logic [CFG_IDX_BITS-1:0] idx, logic [11:0] val);
      if (idx == CFG_MAX_DISP) disp_limit = val;
      else if (idx == CFG_MAX_ROW) row_limit = val;
    endfunction

    // Notes one accepted request and queues the result, if any, that it must cause.
    function void note_request(logic [IN_BITS-1:0] d);
      logic [1:0] mode;
      logic [11:0] px;
      logic [11:0] py;
      logic [ROW_BITS-1:0] rows[PATCH_ROWS];
      match_t res;
      int dx;
      int dy;
      int sad;
      int a;
      int b;
      mode = d[1:0];
      px = d[13:2];
      py = d[25:14];
      for (int r = 0; r < PATCH_ROWS; r++) rows[r] = d[26 + r*ROW_BITS +: ROW_BITS];
      res = '0;
      case (mode)
        MODE_STORE: begin
          if (count >= NCAND) begin
            res.overflow = 1'b1;
            owed = {owed, res};
          end else begin
            tab_x[count] = px;
            tab_y[count] = py;
            for (int r = 0; r < PATCH_ROWS; r++) tab_patch[count][r] = rows[r];
            count++;
          end
        end
        MODE_CLEAR: count = 0;
        MODE_QUERY: begin
          for (int i = 0; i < count; i++) begin
            dx = int'(px) - int'(tab_x[i]);
            dy = int'(py) - int'(tab_y[i]);
            if (dy < 0) dy = -dy;
            if (dx > 0 && dx <= int'(disp_limit) && dy <= int'(row_limit)) begin
              sad = 0;
              for (int r = 0; r < PATCH_ROWS; r++)
                for (int c = 0; c < PATCH_COLS; c++) begin
                  a = rows[r][8*c +: 8];
                  b = tab_patch[i][r][8*c +: 8];
                  sad += (a > b) ? a - b : b - a;
                end
              if (!res.found || sad < int'(res.sad)) begin
                res.found = 1'b1;
                res.sad = sad[13:0];
                res.idx = i[8:0];
                res.x = tab_x[i];
                res.y = tab_y[i];
              end
            end
          end
          owed = {owed, res};
        end
        default: ;
      endcase
    endfunction

    task report(string what, int got, int want);
      $display("mismatch in result %0d: %s is %0d, expected %0d", checked, what, got, want);
      errors++;
    endtask

    // Compares one accepted result with the oldest one owed.
    task check_result(logic [OUT_BITS-1:0] d);
      match_t got;
      match_t want;
      got = d[$bits(match_t)-1:0];
      if (owed.size() == 0) begin
        report("unexpected result", 1, 0);
      end else begin
        want = owed.pop_front();
        if (got.found !== want.found) report("match_found", got.found, want.found);
        if (got.idx !== want.idx) report("best_index", got.idx, want.idx);
        if (got.sad !== want.sad) report("min_sad", got.sad, want.sad);
        if (got.x !== want.x) report("best_x", got.x, want.x);
        if (got.y !== want.y) report("best_y", got.y, want.y);
        if (got.overflow !== want.overflow)
          report("table_overflow", got.overflow, want.overflow);
      end
      checked++;
    endtask
  endclass

  logic clk;
  logic rst_n;
  logic in_tvalid;
  logic in_tready;
  logic [IN_BITS-1:0] in_tdata;
  logic out_tvalid;
  logic out_tready;
  logic [OUT_BITS-1:0] out_tdata;
  logic cfg_we;
  logic [CFG_IDX_BITS-1:0] cfg_index;
  logic [REG_BITS-1:0] cfg_data;

  match_scoreboard board;
  int idle_cycles;
  int sent;
  int stores;
  int queries;
  bit calm;

  keypoint_sad_stereo_matcher_top u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // The receiver stalls in random bursts until the final calm stretch. All
  // handshake bookkeeping happens at the clock edge so the order of events
  // within a time step does not matter.
  initial begin
    int gap;
    out_tready = 1'b0;
    @(posedge clk iff rst_n);
    forever begin
      if (!calm && $urandom_range(0, 3) == 0) begin
        gap = $urandom_range(1, 17);
        out_tready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_tready <= 1'b1;
      @(posedge clk);
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (out_tvalid && out_tready) board.check_result(out_tdata);
      if (in_tvalid && in_tready) board.note_request(in_tdata);
      if ((out_tvalid && out_tready) || (in_tvalid && in_tready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG) begin
        $display("watchdog expired after %0d cycles without a handshake", WATCHDOG);
        $display("CHECKS FAILED");
        $finish;
      end
    end
  end

  function automatic logic [ROW_BITS-1:0] rand_row(int style);
    logic [ROW_BITS-1:0] r;
    for (int c = 0; c < PATCH_COLS; c++)
      case (style)
        0: r[8*c +: 8] = 8'h00;
        1: r[8*c +: 8] = 8'hff;
        2: r[8*c +: 8] = 8'($urandom_range(100, 108));
        default: r[8*c +: 8] = 8'($urandom);
      endcase
    return r;
  endfunction

  // Sends one request, with an occasional burst of sender idling before it.
  task send(logic [1:0] mode, logic [11:0] x, logic [11:0] y, int style);
    logic [IN_BITS-1:0] d;
    int gap;
    d = '0;
    d[1:0] = mode;
    d[13:2] = x;
    d[25:14] = y;
    for (int r = 0; r < PATCH_ROWS; r++)
      d[26 + r*ROW_BITS +: ROW_BITS] = rand_row(style < 0 ? $urandom_range(0, 3) : style);
    if (!calm && $urandom_range(0, 4) == 0) begin
      gap = $urandom_range(1, 17);
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= d;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    sent++;
    if (mode == MODE_STORE) stores++;
    if (mode == MODE_QUERY) queries++;
  endtask

  // Lets everything drain, then gives a query time to finish before a write.
  task drain;
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (board.owed.size() != 0) @(posedge clk);
    repeat (NCAND + 20) @(posedge clk);
  endtask

  // One write, then cfg_we is held low before the task returns, so back-to-back writes never collide.
  task write_reg(logic [CFG_IDX_BITS-1:0] idx, logic [11:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    board.set_reg(idx, val);
    @(posedge clk);
  endtask

  // A well-formed scene: a run of right candidates near a row band, then left
  // queries placed so that a useful share of candidates fall in range.
  task scene(int n_right, int n_left);
    logic [11:0] bx;
    logic [11:0] by;
    bx = 12'($urandom_range(0, 3900));
    by = 12'($urandom_range(0, 4090));
    for (int i = 0; i < n_right; i++)
      send(MODE_STORE, bx + 12'($urandom_range(0, 150)), by + 12'($urandom_range(0, 5)), -1);
    for (int i = 0; i < n_left; i++)
      send(MODE_QUERY, bx + 12'($urandom_range(0, 200)), by + 12'($urandom_range(0, 5)), -1);
  endtask

  initial begin
    logic [11:0] x;
    board = new();
    idle_cycles = 0;
    sent = 0;
    stores = 0;
    queries = 0;
    calm = 1'b0;
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part at reset settings: empty table, extreme pixels, a tie,
    // out-of-range disparities both ways, a clear and an unused mode.
    send(MODE_QUERY, 12'd100, 12'd100, 0);
    send(MODE_STORE, 12'd0, 12'd0, 0);
    send(MODE_STORE, 12'd0, 12'd0, 0);
    send(MODE_STORE, 12'd4095, 12'd4095, 1);
    send(MODE_QUERY, 12'd1, 12'd2, 1);
    send(MODE_QUERY, 12'd0, 12'd0, 0);
    send(MODE_QUERY, 12'd121, 12'd0, 3);
    send(MODE_QUERY, 12'd120, 12'd3, 3);
    send(MODE_QUERY, 12'd0, 12'd4095, 3);
    send(MODE_UNUSED, 12'd4095, 12'd4095, 1);
    send(MODE_CLEAR, 12'd0, 12'd0, 1);
    send(MODE_QUERY, 12'd1, 12'd0, 1);
    drain();

    // Extreme limits, including zero (nothing eligible) and the full range.
    write_reg(CFG_MAX_DISP, 12'd4095);
    write_reg(CFG_MAX_ROW, 12'd4095);
    send(MODE_STORE, 12'd0, 12'd4095, 1);
    send(MODE_QUERY, 12'd4095, 12'd0, 0);
    drain();
    write_reg(CFG_MAX_DISP, 12'd0);
    write_reg(CFG_MAX_ROW, 12'd0);
    send(MODE_QUERY, 12'd4095, 12'd4095, 0);
    send(MODE_CLEAR, 12'd0, 12'd0, 0);
    drain();

    // Fill the table to capacity and push stores past it.
    write_reg(CFG_MAX_DISP, 12'd4095);
    write_reg(CFG_MAX_ROW, 12'd4095);
    for (int i = 0; i < NCAND + 3; i++) begin
      x = 12'($urandom);
      send(MODE_STORE, x, 12'($urandom), -1);
    end
    for (int i = 0; i < 6; i++) send(MODE_QUERY, 12'($urandom), 12'($urandom), -1);
    send(MODE_CLEAR, 12'd0, 12'd0, -1);
    drain();

    // Random scenes over several register settings; small tables keep it fast.
    for (int phase = 0; phase < 6; phase++) begin
      write_reg(CFG_MAX_DISP, phase == 5 ? 12'd120 : 12'($urandom_range(1, 4095)));
      write_reg(CFG_MAX_ROW, phase == 5 ? 12'd2 : 12'($urandom_range(0, 8)));
      if (phase == 5) calm = 1'b1;
      for (int s = 0; s < 10; s++) begin
        send(MODE_CLEAR, 12'($urandom), 12'($urandom), -1);
        scene($urandom_range(1, 10), $urandom_range(1, 6));
        if ($urandom_range(0, 3) == 0)
          send(2'($urandom), 12'($urandom), 12'($urandom), -1);
      end
      drain();
    end

    in_tvalid <= 1'b0;
    @(posedge clk);
    while (board.owed.size() != 0) @(posedge clk);
    repeat (NCAND + 20) @(posedge clk);
    $display("covered %0d requests (%0d stores, %0d queries) and %0d results",
             sent, stores, queries, board.checked);
    $display("table filled past capacity, limits swept from zero to full range");
    if (board.errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

>>> sim.f
rtl/core/ksm_pkg.sv
rtl/core/ksm_ram.sv
rtl/core/ksm_front.sv
rtl/core/ksm_back.sv
rtl/core/keypoint_sad_stereo_matcher_top.sv
tb/sv/keypoint_sad_stereo_matcher_top_test.sv
